/* hw/rtl/wpce_pkg.sv */
// shared types and constants for the wav pcm channel extractor
// no dependencies; used by the parser, the result queue and the top level
`timescale 1ns / 1ps

package wpce_pkg;

    localparam int unsigned POS_W = 27;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam int unsigned MAX_FILE_BYTES_DEF = 100000000;
    localparam logic [POS_W-1:0] MIN_FILE_BYTES = 27'd45;
    localparam logic [POS_W-1:0] TAG_SEARCH_START = 27'd36;
    localparam logic [23:0] TAG_HEAD = 24'h646174;
    localparam logic [7:0] TAG_TAIL = 8'h61;

    localparam int unsigned RES_DEPTH = 4;
    localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
    localparam int unsigned RES_CNT_W = RES_PTR_W + 1;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_LENGTH   = 2'd1,
        ERR_CHANNELS = 2'd2,
        ERR_NO_TAG   = 2'd3
    } t_err;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] sample;
        t_err               err;
        logic [15:0]        chan;
        logic [31:0]        rate;
        logic [15:0]        bits;
        logic [31:0]        size;
    } t_result;

    typedef struct packed {
        logic    first_en;
        logic    second_en;
        t_result first;
        t_result second;
    } t_push;

endpackage

/* hw/rtl/wpce_parser.sv */
// header capture, data tag search and first-channel sample extraction
// depends on wpce_pkg; pushes up to two results per byte into the result queue
`timescale 1ns / 1ps

module wpce_parser #(
    parameter int unsigned MAX_FILE_BYTES = wpce_pkg::MAX_FILE_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wpce_pkg::POS_W-1:0]    i_cfg_data,
    input  logic                          i_accept,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_last_byte,
    output wpce_pkg::t_push               o_push
);

    localparam logic [wpce_pkg::POS_W-1:0] MAX_LEN = wpce_pkg::POS_W'(MAX_FILE_BYTES);

    logic [wpce_pkg::POS_W-1:0] r_file_len;
    logic [wpce_pkg::POS_W-1:0] r_pos,      n_pos;
    logic [31:0]                r_riff,     n_riff;
    logic [15:0]                r_chan,     n_chan;
    logic [31:0]                r_rate,     n_rate;
    logic [15:0]                r_bits,     n_bits;
    logic [23:0]                r_win,      n_win;
    logic                       r_tag,      n_tag;
    logic [31:0]                r_size,     n_size;
    logic [wpce_pkg::POS_W-1:0] r_nsp,      n_nsp;
    logic [32:0]                r_consumed, n_consumed;
    logic [7:0]                 r_low,      n_low;

    logic                       len_ok;
    logic                       in_file;
    logic [wpce_pkg::POS_W:0]   tag_nsp;
    logic [wpce_pkg::POS_W-1:0] size_gap;
    logic [2:0]                 size_sel;
    logic [16:0]                stride;
    logic [33:0]                cons_sum;
    logic [wpce_pkg::POS_W:0]   step_nsp;
    logic                       emit_smp;
    logic                       emit_stat;
    logic signed [15:0]         smp;
    wpce_pkg::t_err             err;
    wpce_pkg::t_result          res_smp;
    wpce_pkg::t_result          res_stat;

    assign len_ok  = (r_file_len >= wpce_pkg::MIN_FILE_BYTES) && (r_file_len <= MAX_LEN);
    assign in_file = r_pos < r_file_len;
    assign tag_nsp = {1'b0, r_pos} + (wpce_pkg::POS_W + 1)'(5);
    assign size_gap = r_nsp - r_pos;
    assign size_sel = 3'd4 - size_gap[2:0];

    always_comb begin
        n_pos      = r_pos;
        n_riff     = r_riff;
        n_chan     = r_chan;
        n_rate     = r_rate;
        n_bits     = r_bits;
        n_win      = r_win;
        n_tag      = r_tag;
        n_size     = r_size;
        n_nsp      = r_nsp;
        n_consumed = r_consumed;
        n_low      = r_low;
        emit_smp   = 1'b0;
        emit_stat  = 1'b0;
        smp        = '0;
        err        = wpce_pkg::ERR_NONE;
        stride     = '0;
        cons_sum   = '0;
        step_nsp   = '0;

        if (in_file) begin
            // little-endian header fields
            if (r_pos inside {[27'd4:27'd7]}) begin
                n_riff = r_riff | ({24'b0, i_data_byte} << {r_pos[1:0], 3'b0});
            end else if (r_pos inside {27'd22, 27'd23}) begin
                n_chan = r_chan | ({8'b0, i_data_byte} << {r_pos[0], 3'b0});
            end else if (r_pos inside {[27'd24:27'd27]}) begin
                n_rate = r_rate | ({24'b0, i_data_byte} << {r_pos[1:0], 3'b0});
            end else if (r_pos inside {27'd34, 27'd35}) begin
                n_bits = r_bits | ({8'b0, i_data_byte} << {r_pos[0], 3'b0});
            end

            if (!r_tag) begin
                if (r_pos >= wpce_pkg::TAG_SEARCH_START + 27'd3 &&
                    ({5'b0, r_pos} + 32'd1) < r_riff &&
                    r_win == wpce_pkg::TAG_HEAD && i_data_byte == wpce_pkg::TAG_TAIL) begin
                    n_tag = 1'b1;
                    n_nsp = tag_nsp[wpce_pkg::POS_W] ? wpce_pkg::POS_MAX
                                                      : tag_nsp[wpce_pkg::POS_W-1:0];
                end
            end else if (r_consumed == '0 && r_pos < r_nsp && size_gap <= 27'd4) begin
                n_size = r_size | ({24'b0, i_data_byte} << {size_sel[1:0], 3'b0});
            end

            n_win = {r_win[15:0], i_data_byte};

            if (n_tag && len_ok && n_chan != '0) begin
                stride   = {n_chan, 1'b0};
                cons_sum = {1'b0, r_consumed} + {17'b0, stride};
                step_nsp = {1'b0, n_nsp} + {11'b0, stride};
                if (r_pos == n_nsp) begin
                    n_low = i_data_byte;
                end else if ({1'b0, r_pos} == {1'b0, n_nsp} + 28'd1 &&
                             cons_sum <= {2'b0, n_size}) begin
                    emit_smp   = 1'b1;
                    smp        = {i_data_byte, r_low};
                    n_consumed = cons_sum[32:0];
                    n_nsp      = step_nsp[wpce_pkg::POS_W] ? wpce_pkg::POS_MAX
                                                            : step_nsp[wpce_pkg::POS_W-1:0];
                end
            end
        end

        if (r_pos != wpce_pkg::POS_MAX) begin
            n_pos = r_pos + 27'd1;
        end

        if (!len_ok) begin
            err = wpce_pkg::ERR_LENGTH;
        end else if (n_chan == '0) begin
            err = wpce_pkg::ERR_CHANNELS;
        end else if (!n_tag) begin
            err = wpce_pkg::ERR_NO_TAG;
        end

        // both results carry the header fields as of this byte
        res_smp.kind   = wpce_pkg::KIND_SAMPLE;
        res_smp.sample = smp;
        res_smp.err    = wpce_pkg::ERR_NONE;
        res_smp.chan   = n_chan;
        res_smp.rate   = n_rate;
        res_smp.bits   = n_bits;
        res_smp.size   = n_size;
        res_stat        = res_smp;
        res_stat.kind   = wpce_pkg::KIND_STATUS;
        res_stat.sample = '0;
        res_stat.err    = err;

        if (i_last_byte) begin
            emit_stat  = 1'b1;
            n_pos      = '0;
            n_riff     = '0;
            n_chan     = '0;
            n_rate     = '0;
            n_bits     = '0;
            n_win      = '0;
            n_tag      = 1'b0;
            n_size     = '0;
            n_nsp      = '0;
            n_consumed = '0;
            n_low      = '0;
        end
    end

    always_comb begin
        o_push.first_en  = i_accept && (emit_smp || emit_stat);
        o_push.second_en = i_accept && emit_smp && emit_stat;
        o_push.first     = emit_smp ? res_smp : res_stat;
        o_push.second    = res_stat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_len <= '0;
            r_pos      <= '0;
            r_riff     <= '0;
            r_chan     <= '0;
            r_rate     <= '0;
            r_bits     <= '0;
            r_win      <= '0;
            r_tag      <= 1'b0;
            r_size     <= '0;
            r_nsp      <= '0;
            r_consumed <= '0;
            r_low      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_file_len <= i_cfg_data;
            end
            if (i_accept) begin
                r_pos      <= n_pos;
                r_riff     <= n_riff;
                r_chan     <= n_chan;
                r_rate     <= n_rate;
                r_bits     <= n_bits;
                r_win      <= n_win;
                r_tag      <= n_tag;
                r_size     <= n_size;
                r_nsp      <= n_nsp;
                r_consumed <= n_consumed;
                r_low      <= n_low;
            end
        end
    end

`ifndef SYNTHESIS
    a_samples_need_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && emit_smp) |-> (r_tag && len_ok))
        else $error("sample emitted without data tag or with bad length");

    a_consumed_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_consumed} <= {2'b0, r_size}))
        else $error("consumed data bytes exceed data size");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_byte) |=> (r_pos == '0 && !r_tag && r_consumed == '0))
        else $error("state not cleared after last byte");
`endif

endmodule

/* hw/rtl/wpce_res_fifo.sv */
// four-entry result queue between the parser and the output channel
// depends on wpce_pkg; takes up to two results per cycle, hands out one when popped
`timescale 1ns / 1ps

module wpce_res_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wpce_pkg::t_push      i_push,
    input  logic                 i_pop,
    output wpce_pkg::t_result    o_head,
    output logic                 o_valid,
    output logic                 o_almost_full
);

    wpce_pkg::t_result                r_mem [wpce_pkg::RES_DEPTH];
    logic [wpce_pkg::RES_PTR_W-1:0]   r_wr, n_wr;
    logic [wpce_pkg::RES_PTR_W-1:0]   r_rd, n_rd;
    logic [wpce_pkg::RES_CNT_W-1:0]   r_count, n_count;
    logic [wpce_pkg::RES_CNT_W-1:0]   push_n;
    logic [wpce_pkg::RES_PTR_W-1:0]   wr_next;
    logic                             pop_ok;

    assign o_valid       = r_count != '0;
    assign o_head        = r_mem[r_rd];
    assign o_almost_full = r_count > wpce_pkg::RES_CNT_W'(wpce_pkg::RES_DEPTH - 2);
    assign pop_ok        = i_pop && o_valid;
    assign wr_next       = r_wr + wpce_pkg::RES_PTR_W'(1);
    assign push_n        = wpce_pkg::RES_CNT_W'(i_push.first_en)
                         + wpce_pkg::RES_CNT_W'(i_push.second_en);

    always_comb begin
        n_wr    = r_wr + push_n[wpce_pkg::RES_PTR_W-1:0];
        n_rd    = pop_ok ? r_rd + wpce_pkg::RES_PTR_W'(1) : r_rd;
        n_count = r_count + push_n - wpce_pkg::RES_CNT_W'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.first_en) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.second_en) begin
            r_mem[wr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= wpce_pkg::RES_CNT_W'(wpce_pkg::RES_DEPTH))
        else $error("result queue count above depth");

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.second_en |-> i_push.first_en)
        else $error("second result pushed without first");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_almost_full |-> !i_push.first_en)
        else $error("push into result queue with fewer than two free entries");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_ok && !i_push.first_en) |=> r_count == $past(r_count) - 1'b1)
        else $error("count did not drop on a lone pop");
`endif

endmodule

/* hw/rtl/wav_pcm_channel_extractor.sv */
// top level of the wav pcm channel extractor
// depends on wpce_pkg, wpce_parser and wpce_res_fifo
`timescale 1ns / 1ps

// Takes one WAV file byte per transfer and can take a byte in every cycle. Each byte is
// handled in the cycle it is accepted; the results it causes (a first-channel sample,
// and on the byte marked last also a status result) go into a four-entry result queue
// that feeds the output channel one result per cycle when not stalled. The input stalls
// while fewer than two queue entries are free, so with the output never stalled the
// block runs at one byte per cycle; a file's last byte may push two results. Write
// file_length through the configuration channel before the first byte of a file.

module wav_pcm_channel_extractor #(
    parameter int unsigned MAX_FILE_BYTES = wpce_pkg::MAX_FILE_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [wpce_pkg::POS_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_last_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_kind,
    output logic signed [15:0]          o_sample,
    output logic [1:0]                  o_error_code,
    output logic [15:0]                 o_channel_count,
    output logic [31:0]                 o_rate_hz,
    output logic [15:0]                 o_sample_bits,
    output logic [31:0]                 o_payload_size
);

    wpce_pkg::t_push   push;
    wpce_pkg::t_result head;
    logic              accept;
    logic              almost_full;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = almost_full;
    assign accept      = i_in_valid && !almost_full;

    wpce_parser #(
        .MAX_FILE_BYTES (MAX_FILE_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (push)
    );

    wpce_res_fifo u_res_fifo (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_pop         (!i_out_stall),
        .o_head        (head),
        .o_valid       (o_out_valid),
        .o_almost_full (almost_full)
    );

    assign o_kind          = head.kind;
    assign o_sample        = head.sample;
    assign o_error_code    = head.err;
    assign o_channel_count = head.chan;
    assign o_rate_hz       = head.rate;
    assign o_sample_bits   = head.bits;
    assign o_payload_size  = head.size;

endmodule

/* test/testbench.sv */
// testbench for wav_pcm_channel_extractor: streams generated wav files byte by byte,
// predicts every sample and status result and checks them in order of arrival
// depends on wpce_pkg and the wav_pcm_channel_extractor rtl
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned LEN_LIMIT = 100000000;
    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned LONG_HOLD = 300;
    localparam int unsigned ITEM_TARGET = 900;
    localparam int FILE_MAX = 512;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       drain;  // offered only once no result is outstanding
    } t_byte_xfer;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [wpce_pkg::POS_W-1:0]  i_cfg_data = '0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [7:0]                  i_data_byte = '0;
    logic                        i_last_byte = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic                        o_kind;
    logic signed [15:0]          o_sample;
    logic [1:0]                  o_error_code;
    logic [15:0]                 o_channel_count;
    logic [31:0]                 o_rate_hz;
    logic [15:0]                 o_sample_bits;
    logic [31:0]                 o_payload_size;

    // parser state as predicted
    logic [wpce_pkg::POS_W-1:0] file_len = '0;
    logic [wpce_pkg::POS_W-1:0] pos_q = '0;
    logic [31:0]                riff_q = '0;
    logic [15:0]                chan_q = '0;
    logic [31:0]                rate_q = '0;
    logic [15:0]                bits_q = '0;
    logic [23:0]                window_q = '0;
    logic                       tag_q = 1'b0;
    logic [31:0]                dsize_q = '0;
    logic [wpce_pkg::POS_W-1:0] next_q = '0;
    logic [32:0]                used_q = '0;
    logic [7:0]                 low_q = '0;

    wpce_pkg::t_result pcm_expected[$];
    t_byte_xfer        byte_queue[$];
    t_byte_xfer        next_byte;
    wpce_pkg::t_result want;
    logic [7:0]        file_img [0:FILE_MAX-1];

    int  send_gap = 0;
    bit  send_idle_on = 1'b1;
    int  bytes_accepted = 0;
    int  recv_wait = 0;
    bit  recv_idle_on = 1'b1;
    int  results_seen = 0;
    int  long_left = 0;
    bit  long_hold_req = 1'b0;
    bit  long_hold_done = 1'b0;
    int  fail_count = 0;
    int  queued_items = 0;
    int  quiet_cycles = 0;

    wav_pcm_channel_extractor u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_sample        (o_sample),
        .o_error_code    (o_error_code),
        .o_channel_count (o_channel_count),
        .o_rate_hz       (o_rate_hz),
        .o_sample_bits   (o_sample_bits),
        .o_payload_size  (o_payload_size)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic bit length_in_range();
        return file_len >= wpce_pkg::MIN_FILE_BYTES && file_len <= LEN_LIMIT;
    endfunction

    function automatic wpce_pkg::t_result make_result(input wpce_pkg::t_kind k,
                                                      input logic [15:0] smp,
                                                      input wpce_pkg::t_err e);
        wpce_pkg::t_result r;
        r.kind   = k;
        r.sample = smp;
        r.err    = e;
        r.chan   = chan_q;
        r.rate   = rate_q;
        r.bits   = bits_q;
        r.size   = dsize_q;
        return r;
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic last);
        longint unsigned p;
        longint unsigned stride;
        longint unsigned nxt;
        wpce_pkg::t_err  status;
        p = longint'(pos_q);
        if (p < file_len) begin
            if (p >= 4 && p <= 7) riff_q = riff_q | (32'(b) << (8 * (p - 4)));
            else if (p == 22 || p == 23) chan_q = chan_q | (16'(b) << (8 * (p - 22)));
            else if (p >= 24 && p <= 27) rate_q = rate_q | (32'(b) << (8 * (p - 24)));
            else if (p == 34 || p == 35) bits_q = bits_q | (16'(b) << (8 * (p - 34)));

            if (!tag_q) begin
                if (p >= wpce_pkg::TAG_SEARCH_START + 3 && p + 1 < riff_q &&
                    window_q == wpce_pkg::TAG_HEAD && b == wpce_pkg::TAG_TAIL) begin
                    tag_q = 1'b1;
                    nxt = p + 5;
                    next_q = (nxt > wpce_pkg::POS_MAX) ? wpce_pkg::POS_MAX
                                                       : nxt[wpce_pkg::POS_W-1:0];
                end
            end else if (used_q == 0 && p + 4 >= next_q && p < next_q) begin
                dsize_q = dsize_q | (32'(b) << (8 * (p + 4 - next_q)));
            end
            window_q = {window_q[15:0], b};

            if (tag_q && length_in_range() && chan_q != 0) begin
                stride = 2 * longint'(chan_q);
                if (p == next_q) begin
                    low_q = b;
                end else if (p == longint'(next_q) + 1 && used_q + stride <= dsize_q) begin
                    pcm_expected.push_back(make_result(wpce_pkg::KIND_SAMPLE, {b, low_q},
                                                       wpce_pkg::ERR_NONE));
                    used_q = 33'(used_q + stride);
                    nxt = longint'(next_q) + stride;
                    next_q = (nxt > wpce_pkg::POS_MAX) ? wpce_pkg::POS_MAX
                                                       : nxt[wpce_pkg::POS_W-1:0];
                end
            end
        end
        if (pos_q != wpce_pkg::POS_MAX) pos_q = pos_q + 1'b1;

        if (last) begin
            if (!length_in_range()) status = wpce_pkg::ERR_LENGTH;
            else if (chan_q == 0) status = wpce_pkg::ERR_CHANNELS;
            else if (!tag_q) status = wpce_pkg::ERR_NO_TAG;
            else status = wpce_pkg::ERR_NONE;
            pcm_expected.push_back(make_result(wpce_pkg::KIND_STATUS, 16'd0, status));
            pos_q = '0;
            riff_q = '0;
            chan_q = '0;
            rate_q = '0;
            bits_q = '0;
            window_q = '0;
            tag_q = 1'b0;
            dsize_q = '0;
            next_q = '0;
            used_q = '0;
            low_q = '0;
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] got);
        if (got !== exp_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, got);
            fail_count++;
        end
    endfunction

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_byte(i_data_byte, i_last_byte);
                bytes_accepted++;
                if (bytes_accepted % 97 == 0) send_idle_on = 1'($urandom_range(1, 0));
                send_gap = send_idle_on ? $urandom_range(9, 0) : 0;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap == 0 && byte_queue.size() != 0 &&
                    !(byte_queue[0].drain && pcm_expected.size() != 0)) begin
                    next_byte = byte_queue.pop_front();
                    i_in_valid <= 1'b1;
                    i_data_byte <= next_byte.data;
                    i_last_byte <= next_byte.last;
                end else begin
                    i_in_valid <= 1'b0;
                    if (send_gap > 0) send_gap--;
                end
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pcm_expected.size() == 0) begin
                    $error("unexpected result: kind %0d sample %0h status %0d",
                           o_kind, o_sample, o_error_code);
                    fail_count++;
                end else begin
                    want = pcm_expected.pop_front();
                    check_field("kind", 32'(want.kind), 32'(o_kind));
                    check_field("sample", 32'(want.sample), 32'(o_sample));
                    check_field("error_code", 32'(want.err), 32'(o_error_code));
                    check_field("channel_count", 32'(want.chan), 32'(o_channel_count));
                    check_field("rate_hz", want.rate, o_rate_hz);
                    check_field("sample_bits", 32'(want.bits), 32'(o_sample_bits));
                    check_field("payload_size", want.size, o_payload_size);
                end
                results_seen++;
                if (results_seen % 41 == 0) recv_idle_on = 1'($urandom_range(1, 0));
                recv_wait = recv_idle_on ? $urandom_range(9, 0) : 0;
            end else if (recv_wait > 0) begin
                recv_wait--;
            end
            if (long_hold_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                long_left = LONG_HOLD;
            end
            if (long_left > 0) long_left--;
            i_out_stall <= (recv_wait != 0) || (long_left != 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall && pcm_expected.size() != 0) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        while (byte_queue.size() != 0 || i_in_valid || pcm_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_length(input logic [wpce_pkg::POS_W-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        file_len = value;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void put_le(input int at, input logic [31:0] value, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            if (at + i < FILE_MAX) file_img[at + i] = value[8*i +: 8];
    endfunction

    function automatic void queue_file(input logic [15:0] chans, input logic [31:0] rate,
                                       input logic [15:0] bits, input logic [31:0] riff,
                                       input int pad, input bit with_tag,
                                       input logic [31:0] dsize, input int stream_len,
                                       input int drain_at);
        t_byte_xfer x;
        for (int i = 0; i < stream_len; i++) file_img[i] = 8'($urandom);
        put_le(0, 32'h46464952, 4);
        put_le(4, riff, 4);
        put_le(8, 32'h45564157, 4);
        put_le(12, 32'h20746d66, 4);
        put_le(16, 32'd16, 4);
        put_le(20, 32'd1, 2);
        put_le(22, 32'(chans), 2);
        put_le(24, rate, 4);
        put_le(32, 2 * 32'(chans), 2);
        put_le(34, 32'(bits), 2);
        // near miss "datb" when the tag is to be absent
        put_le(36 + pad, with_tag ? 32'h61746164 : 32'h62746164, 4);
        put_le(40 + pad, dsize, 4);
        for (int i = 0; i < stream_len; i++) begin
            x.data = file_img[i];
            x.last = (i == stream_len - 1);
            x.drain = (i == drain_at);
            byte_queue.push_back(x);
        end
        queued_items += stream_len;
    endfunction

    task automatic queue_random_file(input int target);
        int          pick;
        int          stream_len;
        int          pad;
        int          remaining;
        int          drain_at;
        logic [15:0] chans;
        logic [31:0] riff;
        logic [31:0] dsize;
        pick = $urandom_range(9, 0);
        if (pick < 7) stream_len = target;
        else if (pick < 8) stream_len = target - $urandom_range(6, 1);
        else stream_len = target + $urandom_range(6, 1);
        if (stream_len < 1) stream_len = 1;
        pick = $urandom_range(19, 0);
        if (pick < 1) chans = 16'd0;
        else if (pick < 2) chans = 16'($urandom);
        else chans = 16'($urandom_range(4, 1));
        pad = ($urandom_range(2, 0) == 0) ? $urandom_range(12, 1) : 0;
        remaining = stream_len - 44 - pad;
        if (remaining < 0) remaining = 0;
        pick = $urandom_range(9, 0);
        if (pick < 8) riff = 32'(stream_len - 8);
        else if (pick < 9) riff = $urandom_range(40, 0);
        else riff = $urandom;
        pick = $urandom_range(9, 0);
        if (pick < 7) dsize = remaining;
        else if (pick < 8) dsize = (remaining > 5) ? remaining - $urandom_range(5, 0) : 0;
        else if (pick < 9) dsize = $urandom;
        else dsize = remaining + $urandom_range(8, 1);
        drain_at = ($urandom_range(9, 0) == 0) ? $urandom_range(stream_len - 1, 0) : -1;
        queue_file(chans, $urandom, ($urandom_range(1, 0) != 0) ? 16'd16 : 16'($urandom),
                   riff, pad, $urandom_range(9, 0) != 0, dsize, stream_len, drain_at);
    endtask

    task automatic queue_random_phase();
        int                         pick;
        int                         target;
        int                         files;
        logic [wpce_pkg::POS_W-1:0] len;
        pick = $urandom_range(99, 0);
        if (pick < 70) len = wpce_pkg::POS_W'($urandom_range(160, 45));
        else if (pick < 80) len = wpce_pkg::POS_W'($urandom_range(44, 0));
        else if (pick < 90) len = wpce_pkg::POS_W'($urandom_range(LEN_LIMIT, LEN_LIMIT - 1000));
        else len = wpce_pkg::POS_W'($urandom_range(wpce_pkg::POS_MAX, LEN_LIMIT + 1));
        set_length(len);
        if (len == 0) target = 1;
        else if (len <= 160) target = int'(len);
        else target = $urandom_range(160, 45);
        files = $urandom_range(3, 1);
        for (int f = 0; f < files && queued_items < ITEM_TARGET; f++)
            queue_random_file(target);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero length: lone last byte
        set_length('0);
        queue_file(16'd1, 32'd44100, 16'd16, 32'd36, 0, 1'b1, 32'd0, 1, -1);
        // one below the minimum
        set_length(27'd44);
        queue_file(16'd1, 32'd8000, 16'd16, 32'd36, 0, 1'b1, 32'd0, 44, -1);
        // minimum length: riff too small for the tag, then a half sample
        set_length(27'd45);
        queue_file(16'd1, 32'd22050, 16'd16, 32'd37, 0, 1'b1, 32'd2, 45, -1);
        queue_file(16'd1, 32'd22050, 16'd16, 32'hffffffff, 0, 1'b1, 32'd2, 45, -1);
        // above the maximum, and the largest register value
        set_length(27'(LEN_LIMIT + 1));
        queue_file(16'd2, 32'd48000, 16'd16, 32'd52, 0, 1'b1, 32'd8, 60, -1);
        set_length(wpce_pkg::POS_MAX);
        queue_file(16'd2, 32'd48000, 16'd16, 32'd52, 0, 1'b1, 32'd8, 60, -1);
        // maximum accepted length, pause mid file until all results are in
        set_length(27'(LEN_LIMIT));
        queue_file(16'd2, 32'd96000, 16'd24, 32'd62, 0, 1'b1, 32'd26, 70, 55);
        // bytes past the length are ignored; the sample cut by it is dropped
        set_length(27'd101);
        queue_file(16'd1, 32'd11025, 16'd8, 32'd102, 0, 1'b1, 32'd66, 110, -1);
        // zero channels, then no tag
        set_length(27'd80);
        queue_file(16'd0, 32'd44100, 16'd16, 32'd72, 0, 1'b1, 32'd36, 80, -1);
        queue_file(16'd1, 32'd44100, 16'd16, 32'd72, 0, 1'b0, 32'd36, 80, -1);
        // all-ones header fields with padding before the tag
        set_length(27'd100);
        queue_file(16'hffff, 32'hffffffff, 16'hffff, 32'hffffffff, 5, 1'b1, 32'hffffffff,
                   100, -1);
        // receiver holds off while a mono file streams in
        set_length(27'd120);
        long_hold_req = 1'b1;
        queue_file(16'd1, 32'd44100, 16'd16, 32'd112, 0, 1'b1, 32'd76, 120, -1);

        while (queued_items < ITEM_TARGET) queue_random_phase();

        wait_idle();
        if (fail_count == 0 && pcm_expected.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
